>>> rtl/tsnb_pkg.sv
// Shared types, constants and helpers of the texture sampler.
package tsnb_pkg;

  localparam int MAX_TEX_WIDTH    = 256;
  localparam int MAX_TEX_HEIGHT   = 256;
  localparam int WEIGHT_FRAC_BITS = 8;

  localparam int COORD_W    = 18;
  localparam int COORD_FRAC = 16;
  localparam int SIZE_W     = 9;
  localparam int ADDR_W     = 16;
  localparam int CHAN_W     = 8;
  localparam int TEXEL_W    = 3 * CHAN_W;
  localparam int CFG_IDX_W  = 2;

  localparam int STORE_DEPTH = MAX_TEX_WIDTH * MAX_TEX_HEIGHT;
  localparam int BANK_DEPTH  = (STORE_DEPTH + 1) / 2;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);

  // scaled coordinate p = u * w, signed
  localparam int P_W    = COORD_W + SIZE_W + 1;
  // integer part of a nonnegative p
  localparam int IX_W   = P_W - 1 - COORD_FRAC;
  localparam int ROW_W  = 2 * SIZE_W + 1;
  localparam int WT_W   = 2 * WEIGHT_FRAC_BITS + 1;
  localparam int CP_W   = CHAN_W + WT_W;
  localparam int SUM_W  = CP_W + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SIZE_W-1:0] TEX_SIZE_RESET = SIZE_W'(256);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH   = 2'd0,
    REG_TEX_HEIGHT  = 2'd1,
    REG_FILTER_MODE = 2'd2
  } cfg_idx_t;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  // One classified item on its way from front to back.
  typedef struct packed {
    op_t                         op;
    logic                        hit;   // sample in range, or write inside store
    logic [ROW_W-1:0]            row0;  // linear index of (x0,y0), or write address
    logic [ROW_W-1:0]            row1;  // linear index of (x0,y0+1)
    logic [WEIGHT_FRAC_BITS-1:0] fx;
    logic [WEIGHT_FRAC_BITS-1:0] fy;
    logic [TEXEL_W-1:0]          texel;
  } q_item_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s,
                                                   input int maxv);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    else if (32'(s) > 32'(maxv)) r = SIZE_W'(maxv);
    return r;
  endfunction

endpackage

>>> rtl/tsnb_req_if.sv
// Request channel: texel writes and sample requests.
interface tsnb_req_if;
  import tsnb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [ADDR_W-1:0]         texel_addr;
  logic [CHAN_W-1:0]         in_red;
  logic [CHAN_W-1:0]         in_green;
  logic [CHAN_W-1:0]         in_blue;
  logic signed [COORD_W-1:0] coord_u;
  logic signed [COORD_W-1:0] coord_v;
  modport source (output valid, cmd, texel_addr, in_red, in_green, in_blue, coord_u, coord_v,
                  input ready);
  modport sink   (input valid, cmd, texel_addr, in_red, in_green, in_blue, coord_u, coord_v,
                  output ready);
endinterface

>>> rtl/tsnb_rsp_if.sv
// Response channel: filtered color per sample.
interface tsnb_rsp_if;
  import tsnb_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  modport source (output valid, hit, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, hit, out_red, out_green, out_blue, output ready);
endinterface

>>> rtl/tsnb_cfg_if.sv
// Configuration write channel.
interface tsnb_cfg_if;
  import tsnb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tsnb_front.sv
// Front end: config registers, coordinate scaling, range check and addressing.
module tsnb_front (
  input  logic              clk,
  input  logic              rst,
  tsnb_req_if.sink          req,
  tsnb_cfg_if.sink          cfg,
  input  logic              q_full,
  output logic              q_push,
  output tsnb_pkg::q_item_t q_item
);
  import tsnb_pkg::*;

  logic [SIZE_W-1:0] tex_width;
  logic [SIZE_W-1:0] tex_height;
  logic              filter_mode;

  logic              f1_valid;
  op_t               f1_op;
  logic [ADDR_W-1:0] f1_addr;
  logic [TEXEL_W-1:0] f1_texel;
  logic signed [P_W-1:0] f1_p;
  logic signed [P_W-1:0] f1_q;
  logic [SIZE_W-1:0] f1_w;
  logic [SIZE_W-1:0] f1_h;
  logic              f1_mode;

  logic [SIZE_W-1:0] w_cl;
  logic [SIZE_W-1:0] h_cl;
  logic              accept;

  logic              neg;
  logic [IX_W-1:0]   x0;
  logic [IX_W-1:0]   y0;
  logic [COORD_FRAC-1:0] fxr;
  logic [COORD_FRAC-1:0] fyr;
  logic [IX_W:0]     x1;
  logic [IX_W:0]     y1;
  logic              in_base;
  logic              in_far;
  logic [2*SIZE_W-1:0] m0;
  logic [ROW_W-1:0]  m1;
  logic [SIZE_W:0]   y0p1;

  assign cfg.ready = 1'b1;
  assign w_cl = clamp_size(tex_width, MAX_TEX_WIDTH);
  assign h_cl = clamp_size(tex_height, MAX_TEX_HEIGHT);
  assign req.ready = !f1_valid || !q_full;
  assign accept = req.valid && req.ready;
  assign q_push = f1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= TEX_SIZE_RESET;
      tex_height  <= TEX_SIZE_RESET;
      filter_mode <= MODE_NEAREST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TEX_WIDTH:   tex_width   <= cfg.data;
        REG_TEX_HEIGHT:  tex_height  <= cfg.data;
        REG_FILTER_MODE: filter_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (req.ready) begin
      f1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op    <= op_t'(req.cmd);
      f1_addr  <= req.texel_addr;
      f1_texel <= {req.in_red, req.in_green, req.in_blue};
      f1_p     <= $signed(req.coord_u) * $signed({1'b0, w_cl});
      f1_q     <= $signed(req.coord_v) * $signed({1'b0, h_cl});
      f1_w     <= w_cl;
      f1_h     <= h_cl;
      f1_mode  <= filter_mode;
    end
  end

  always_comb begin
    neg  = f1_p[P_W-1] | f1_q[P_W-1];
    x0   = f1_p[P_W-2:COORD_FRAC];
    y0   = f1_q[P_W-2:COORD_FRAC];
    fxr  = f1_p[COORD_FRAC-1:0];
    fyr  = f1_q[COORD_FRAC-1:0];
    x1   = (IX_W+1)'(x0) + (IX_W+1)'(fxr != '0);
    y1   = (IX_W+1)'(y0) + (IX_W+1)'(fyr != '0);
    in_base = !neg && (x0 < IX_W'(f1_w)) && (y0 < IX_W'(f1_h));
    in_far  = (x1 < (IX_W+1)'(f1_w)) && (y1 < (IX_W+1)'(f1_h));
    y0p1 = (SIZE_W+1)'(y0[SIZE_W-1:0]) + (SIZE_W+1)'(1);
    m0   = y0[SIZE_W-1:0] * f1_w;
    m1   = y0p1 * f1_w;

    q_item       = '0;
    q_item.op    = f1_op;
    q_item.texel = f1_texel;
    if (f1_op == OP_WRITE) begin
      q_item.row0 = ROW_W'(f1_addr);
      q_item.hit  = 32'(f1_addr) < 32'(STORE_DEPTH);
    end else begin
      q_item.row0 = ROW_W'(m0) + ROW_W'(x0[SIZE_W-1:0]);
      q_item.row1 = m1 + ROW_W'(x0[SIZE_W-1:0]);
      if (f1_mode == MODE_BILINEAR) begin
        q_item.hit = in_base && in_far;
        q_item.fx  = fxr[COORD_FRAC-1 -: WEIGHT_FRAC_BITS];
        q_item.fy  = fyr[COORD_FRAC-1 -: WEIGHT_FRAC_BITS];
      end else begin
        q_item.hit = in_base;
      end
    end
  end

endmodule

>>> rtl/tsnb_queue.sv
// Small FIFO between the front end and the back end.
module tsnb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsnb_pkg::q_item_t wr_item,
  input  logic              pop,
  output tsnb_pkg::q_item_t rd_item,
  output logic              full,
  output logic              empty
);
  import tsnb_pkg::*;

  q_item_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_item;
  end

endmodule

>>> rtl/tsnb_back.sv
// Back end: banked texel store, corner fetch, weighting and output register.
module tsnb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  tsnb_pkg::q_item_t q_item,
  output logic              q_pop,
  tsnb_rsp_if.source        rsp
);
  import tsnb_pkg::*;

  localparam int WFB = WEIGHT_FRAC_BITS;
  localparam logic [WFB:0] WT_ONE = (WFB+1)'(1) << WFB;
  localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (2*WFB - 1);

  // two copies (upper and lower row), each split into even and odd banks
  logic [TEXEL_W-1:0] mem_ae [BANK_DEPTH];
  logic [TEXEL_W-1:0] mem_ao [BANK_DEPTH];
  logic [TEXEL_W-1:0] mem_be [BANK_DEPTH];
  logic [TEXEL_W-1:0] mem_bo [BANK_DEPTH];
  logic [TEXEL_W-1:0] rd_ae, rd_ao, rd_be, rd_bo;

  logic               en;
  logic               wr;
  logic [BANK_AW-1:0] ae, ao, be, bo, widx;

  logic [WFB:0]       nfx, nfy;

  logic               b1_valid;
  op_t                b1_op;
  logic               b1_hit, b1_fx_nz, b1_fy_nz, b1_par0, b1_par1;
  logic [WT_W-1:0]    b1_wt [4];

  logic [TEXEL_W-1:0] corner [4];

  logic               b2_valid;
  op_t                b2_op;
  logic               b2_hit;
  logic [CP_W-1:0]    b2_prod [3][4];

  logic               out_valid;
  logic               out_hit;
  logic [CHAN_W-1:0]  out_chan [3];
  logic [SUM_W-1:0]   sum [3];

  assign en    = !out_valid || rsp.ready;
  assign q_pop = en && !q_empty;
  assign wr    = q_pop && (q_item.op == OP_WRITE) && q_item.hit;

  assign ao   = BANK_AW'(q_item.row0 >> 1);
  assign ae   = BANK_AW'(ROW_W'(q_item.row0 + ROW_W'(1)) >> 1);
  assign bo   = BANK_AW'(q_item.row1 >> 1);
  assign be   = BANK_AW'(ROW_W'(q_item.row1 + ROW_W'(1)) >> 1);
  assign widx = BANK_AW'(q_item.row0 >> 1);

  assign nfx = WT_ONE - (WFB+1)'(q_item.fx);
  assign nfy = WT_ONE - (WFB+1)'(q_item.fy);

  // banks: write both copies, read one entry per bank per cycle while en is high
  always_ff @(posedge clk) begin
    if (en) rd_ae <= mem_ae[ae];
    if (wr && !q_item.row0[0]) mem_ae[widx] <= q_item.texel;
  end
  always_ff @(posedge clk) begin
    if (en) rd_ao <= mem_ao[ao];
    if (wr && q_item.row0[0]) mem_ao[widx] <= q_item.texel;
  end
  always_ff @(posedge clk) begin
    if (en) rd_be <= mem_be[be];
    if (wr && !q_item.row0[0]) mem_be[widx] <= q_item.texel;
  end
  always_ff @(posedge clk) begin
    if (en) rd_bo <= mem_bo[bo];
    if (wr && q_item.row0[0]) mem_bo[widx] <= q_item.texel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= q_pop;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid && (b2_op == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_op    <= q_item.op;
      b1_hit   <= q_item.hit;
      b1_fx_nz <= q_item.fx != '0;
      b1_fy_nz <= q_item.fy != '0;
      b1_par0  <= q_item.row0[0];
      b1_par1  <= q_item.row1[0];
      b1_wt[0] <= WT_W'(nfx) * WT_W'(nfy);
      b1_wt[1] <= WT_W'(q_item.fx) * WT_W'(nfy);
      b1_wt[2] <= WT_W'(nfx) * WT_W'(q_item.fy);
      b1_wt[3] <= WT_W'(q_item.fx) * WT_W'(q_item.fy);
    end
  end

  // route banks to corners; zero corners whose weight is zero, and all corners on a miss
  always_comb begin
    corner[0] = b1_par0 ? rd_ao : rd_ae;
    corner[1] = b1_par0 ? rd_ae : rd_ao;
    corner[2] = b1_par1 ? rd_bo : rd_be;
    corner[3] = b1_par1 ? rd_be : rd_bo;
    if (!b1_fx_nz) begin
      corner[1] = '0;
      corner[3] = '0;
    end
    if (!b1_fy_nz) begin
      corner[2] = '0;
      corner[3] = '0;
    end
    if (!b1_hit) begin
      for (int c = 0; c < 4; c++) corner[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_op  <= b1_op;
      b2_hit <= b1_hit;
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 4; c++) begin
          b2_prod[k][c] <= CP_W'(corner[c][TEXEL_W-1-CHAN_W*k -: CHAN_W])
                         * CP_W'(b1_wt[c]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUM_W'(b2_prod[k][0]) + SUM_W'(b2_prod[k][1]) + SUM_W'(b2_prod[k][2])
             + SUM_W'(b2_prod[k][3]) + ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit <= b2_hit;
      for (int k = 0; k < 3; k++) begin
        out_chan[k] <= b2_hit ? sum[k][2*WFB +: CHAN_W] : '0;
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.hit       = out_hit;
  assign rsp.out_red   = out_chan[0];
  assign rsp.out_green = out_chan[1];
  assign rsp.out_blue  = out_chan[2];

endmodule

>>> rtl/texture_sampler_nearest_bilinear.sv
// Top level of the nearest/bilinear texture sampler.
// A sample's result passes the scale register, queue, bank read, weighting and output
// register in that order; a stall on rsp can hold it between them.
// Throughput: one item per cycle while rsp does not stall; four texel reads a cycle come from four banks.
// A stalled rsp fills the 4-entry queue before req.ready drops.
// Reset (rst, synchronous): width and height 256, nearest mode, pipeline empty;
// the texel store is not cleared and holds garbage until written.
module texture_sampler_nearest_bilinear (
  input  logic       clk,
  input  logic       rst,
  tsnb_req_if.sink   req,
  tsnb_cfg_if.sink   cfg,
  tsnb_rsp_if.source rsp
);
  import tsnb_pkg::*;

  // front -> queue -> back
  q_item_t push_item;
  q_item_t pop_item;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;

  // Front: hold config, scale u,v by the texture size, classify and address
  // each item; stall only when the queue is full.
  tsnb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  // Queue: decouple the two halves so a stalled rsp does not stop req at once.
  tsnb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (push_item),
    .pop     (q_pop),
    .rd_item (pop_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: write texels or fetch four corners and blend; advance the whole back-end
  // pipeline only while the output register can take a result.
  tsnb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (pop_item),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

>>> rtl/tsnb_checker.sv
// Port-level assertions for the texture sampler and their bind.
module tsnb_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_cmd,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       hit,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);
  import tsnb_pkg::*;

  logic [3:0] pending;
  logic       take_sample;
  logic       give;

  assign take_sample = req_valid && req_ready && (req_cmd == OP_SAMPLE);
  assign give        = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(take_sample) - 4'(give);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pending != 4'd0))
    else $error("result without a pending sample");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !hit) |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("miss with nonzero color");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(hit) && $stable(out_red)
                                   && $stable(out_green) && $stable(out_blue)))
    else $error("stalled result changed");

endmodule

bind texture_sampler_nearest_bilinear tsnb_checker u_tsnb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_cmd   (req.cmd),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .hit       (rsp.hit),
  .out_red   (rsp.out_red),
  .out_green (rsp.out_green),
  .out_blue  (rsp.out_blue)
);

>>> tb/sv/texture_sampler_nearest_bilinear_tb.sv
// Self-checking testbench of the nearest/bilinear texture sampler.
module texture_sampler_nearest_bilinear_tb;
  import tsnb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 10;

  typedef enum int {ROW_WRITE, ROW_SAMPLE, ROW_CFG} row_kind_t;

  // One line of the directed stimulus table; typed rows carry their color.
  typedef struct {
    row_kind_t         kind;
    int                addr;   // texel address, or register index for ROW_CFG
    int                data;   // packed RGB for writes, register value for ROW_CFG
    logic signed [17:0] u;
    logic signed [17:0] v;
    bit                typed;
    logic [24:0]       want;   // {hit, r, g, b}
  } stim_row_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct {
    int w, h, mode, count;
  } phase_t;

  logic clk;
  logic rst;

  tsnb_req_if req ();
  tsnb_cfg_if cfg ();
  tsnb_rsp_if rsp ();

  texture_sampler_nearest_bilinear u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cfg (cfg),
    .rsp (rsp)
  );

  // Shadow of the texture and registers, advanced at each accepted item.
  logic [23:0]        texels [65536];
  bit                 written [65536];
  logic [SIZE_W-1:0]  shadow_w;
  logic [SIZE_W-1:0]  shadow_h;
  logic               shadow_mode;

  color_t    color_q[$];
  stim_row_t rows[$];
  int        err_cnt;
  int        cycle_cnt;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_left;
  int        sent;     // items accepted, fills included

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("texture_sampler_nearest_bilinear_tb: done, errors");
      $finish;
    end
  end

  // Receiver: a long hold-off wins over the random idling.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // Compare every delivered color with the oldest one still owed.
  always @(posedge clk) begin
    color_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (color_q.size() == 0) begin
        mismatch("unexpected result, hit", rsp.hit, 0);
      end else begin
        want = color_q.pop_front();
        if (rsp.hit !== want.hit) mismatch("hit", rsp.hit, want.hit);
        if (rsp.out_red !== want.red) mismatch("red", rsp.out_red, want.red);
        if (rsp.out_green !== want.green) mismatch("green", rsp.out_green, want.green);
        if (rsp.out_blue !== want.blue) mismatch("blue", rsp.out_blue, want.blue);
      end
    end
  end

  function automatic int eff_size(input logic [SIZE_W-1:0] s, input int maxv);
    if (s == 0) return 1;
    if (int'(s) > maxv) return maxv;
    return int'(s);
  endfunction

  // Find the texels a sample touches; 0 means the sample misses.
  function automatic bit find_corners(input logic signed [17:0] u, input logic signed [17:0] v,
                                      output int x0, output int y0, output int x1,
                                      output int y1, output int fx, output int fy);
    longint p, q;
    int     w, h;
    w = eff_size(shadow_w, MAX_TEX_WIDTH);
    h = eff_size(shadow_h, MAX_TEX_HEIGHT);
    p = longint'(u) * w;
    q = longint'(v) * h;
    x0 = 0; y0 = 0; x1 = 0; y1 = 0; fx = 0; fy = 0;
    if (p < 0 || q < 0) return 1'b0;
    x0 = int'(p >> 16);
    y0 = int'(q >> 16);
    if (x0 >= w || y0 >= h) return 1'b0;
    x1 = x0;
    y1 = y0;
    if (shadow_mode == MODE_BILINEAR) begin
      x1 = x0 + ((p & 65535) != 0);
      y1 = y0 + ((q & 65535) != 0);
      if (x1 >= w || y1 >= h) return 1'b0;
      fx = int'((p & 65535) >> 8);
      fy = int'((q & 65535) >> 8);
    end
    return 1'b1;
  endfunction

  function automatic color_t filtered_color(input logic signed [17:0] u,
                                            input logic signed [17:0] v);
    color_t      c;
    int          x0, y0, x1, y1, fx, fy, w, sh;
    logic [23:0] t00, t10, t01, t11;
    longint      s;
    c = '0;
    if (!find_corners(u, v, x0, y0, x1, y1, fx, fy)) return c;
    w   = eff_size(shadow_w, MAX_TEX_WIDTH);
    t00 = texels[y0 * w + x0];
    c.hit = 1'b1;
    if (shadow_mode == MODE_NEAREST) begin
      {c.red, c.green, c.blue} = t00;
      return c;
    end
    t10 = texels[y0 * w + x1];
    t01 = texels[y1 * w + x0];
    t11 = texels[y1 * w + x1];
    for (int k = 0; k < 3; k++) begin
      sh = 16 - 8 * k;
      s = longint'((t00 >> sh) & 8'hFF) * (256 - fx) * (256 - fy)
        + longint'((t10 >> sh) & 8'hFF) * fx * (256 - fy)
        + longint'((t01 >> sh) & 8'hFF) * (256 - fx) * fy
        + longint'((t11 >> sh) & 8'hFF) * fx * fy + 32768;
      s = s >> 16;
      if (k == 0) c.red = 8'(s);
      else if (k == 1) c.green = 8'(s);
      else c.blue = 8'(s);
    end
    return c;
  endfunction

  // Offer one item; return at the edge that accepts it. Keep valid high between items.
  task automatic put_item(input op_t op, input logic [15:0] addr, input logic [23:0] rgb,
                          input logic signed [17:0] u, input logic signed [17:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.cmd        <= op;
    req.texel_addr <= addr;
    {req.in_red, req.in_green, req.in_blue} <= rgb;
    req.coord_u    <= u;
    req.coord_v    <= v;
    forever begin
      @(posedge clk);
      if (req.ready) break;
    end
    sent++;
  endtask

  task automatic write_texel(input logic [15:0] addr, input logic [23:0] rgb);
    put_item(OP_WRITE, addr, rgb, 18'($urandom), 18'($urandom));
    texels[addr]  = rgb;
    written[addr] = 1'b1;
  endtask

  // Fill any texel the sample would read that has never been written, then sample.
  task automatic sample_at(input logic signed [17:0] u, input logic signed [17:0] v,
                           input bit typed, input color_t want);
    int x0, y0, x1, y1, fx, fy, w;
    int idx[4];
    w = eff_size(shadow_w, MAX_TEX_WIDTH);
    if (find_corners(u, v, x0, y0, x1, y1, fx, fy)) begin
      idx = '{y0 * w + x0, y0 * w + x1, y1 * w + x0, y1 * w + x1};
      foreach (idx[i])
        if (!written[idx[i]]) write_texel(16'(idx[i]), 24'($urandom));
    end
    put_item(OP_SAMPLE, 16'($urandom), 24'($urandom), u, v);
    color_q.push_back(typed ? want : filtered_color(u, v));
  endtask

  // Let every owed result arrive, then let the pipeline empty of writes.
  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t index, input logic [SIZE_W-1:0] value);
    drain();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= value;
    forever begin
      @(posedge clk);
      if (cfg.ready) break;
    end
    case (index)
      REG_TEX_WIDTH:  shadow_w = value;
      REG_TEX_HEIGHT: shadow_h = value;
      default:        shadow_mode = value[0];
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic stim_row_t mk(input row_kind_t kind, input int addr, input int data,
                                   input int u, input int v, input bit typed,
                                   input logic [24:0] want);
    stim_row_t r;
    r.kind = kind; r.addr = addr; r.data = data;
    r.u = 18'(u); r.v = 18'(v); r.typed = typed; r.want = want;
    return r;
  endfunction

  initial begin
    phase_t     phases[8];
    stim_row_t  r;
    int         total, phase_end, w, h;
    bit         held_mid, held_late, paused;
    logic signed [17:0] u, v;

    rst = 1'b1;
    req.valid = 1'b0; req.cmd = OP_WRITE; req.texel_addr = '0;
    req.in_red = '0; req.in_green = '0; req.in_blue = '0;
    req.coord_u = '0; req.coord_v = '0;
    cfg.valid = 1'b0; cfg.index = REG_TEX_WIDTH; cfg.data = '0;
    rsp.ready = 1'b0;
    err_cnt = 0; cycle_cnt = 0; hold_left = 0; sent = 0;
    send_idle_pct = 30; recv_idle_pct = 71;
    shadow_w = TEX_SIZE_RESET; shadow_h = TEX_SIZE_RESET; shadow_mode = MODE_NEAREST;

    // Directed: reset size in nearest mode, then small bilinear and clamped sizes.
    rows.push_back(mk(ROW_WRITE, 0, 24'hFF0080, 0, 0, 0, '0));
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 0, 0, 1, {1'b1, 24'hFF0080}));
    rows.push_back(mk(ROW_SAMPLE, 0, 0, -1, 0, 1, '0));           // negative u
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 0, -131072, 1, '0));      // most negative v
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 131071, 0, 1, '0));       // far right
    rows.push_back(mk(ROW_WRITE, 65535, 24'h01FE7F, 0, 0, 0, '0));
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 65535, 65535, 1, {1'b1, 24'h01FE7F}));
    rows.push_back(mk(ROW_CFG, REG_TEX_WIDTH, 4, 0, 0, 0, '0));
    rows.push_back(mk(ROW_CFG, REG_TEX_HEIGHT, 3, 0, 0, 0, '0));
    rows.push_back(mk(ROW_CFG, REG_FILTER_MODE, MODE_BILINEAR, 0, 0, 0, '0));
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 'h8000, 0, 0, '0));       // exact p and q
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 'h6000, 'h5555, 0, '0));
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 'hF000, 0, 1, '0));       // right neighbor outside
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 'hFFFF, 'hFFFF, 1, '0));
    rows.push_back(mk(ROW_WRITE, 40000, 24'hAA550F, 0, 0, 0, '0)); // past width*height
    rows.push_back(mk(ROW_CFG, REG_TEX_WIDTH, 0, 0, 0, 0, '0));    // acts as 1
    rows.push_back(mk(ROW_CFG, REG_TEX_HEIGHT, 511, 0, 0, 0, '0)); // acts as 256
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 0, 'h0100, 0, '0));
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 'h10000, 0, 1, '0));      // u = 1.0 with width 1
    rows.push_back(mk(ROW_CFG, REG_FILTER_MODE, MODE_NEAREST, 0, 0, 0, '0));
    rows.push_back(mk(ROW_SAMPLE, 0, 0, 'h4000, 'h8000, 0, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      r = rows[i];
      case (r.kind)
        ROW_WRITE:  write_texel(16'(r.addr), 24'(r.data));
        ROW_SAMPLE: sample_at(r.u, r.v, r.typed, color_t'(r.want));
        default:    write_reg(cfg_idx_t'(r.addr), SIZE_W'(r.data));
      endcase
    end

    // Phase counts are items sent, fills of unwritten texels included.
    phases = '{'{12, 10, 1, 260}, '{256, 256, 0, 200}, '{3, 7, 1, 260}, '{300, 5, 1, 240},
               '{1, 1, 0, 160}, '{9, 2, 1, 260}, '{256, 256, 1, 200}, '{16, 16, 0, 320}};
    total = 0;
    foreach (phases[i]) total += phases[i].count;
    sent = 0;
    phase_end = 0;
    held_mid = 1'b0; held_late = 1'b0; paused = 1'b0;

    foreach (phases[i]) begin
      write_reg(REG_TEX_WIDTH, SIZE_W'(phases[i].w));
      write_reg(REG_TEX_HEIGHT, SIZE_W'(phases[i].h));
      write_reg(REG_FILTER_MODE, SIZE_W'(phases[i].mode));
      phase_end += phases[i].count;
      w = eff_size(shadow_w, MAX_TEX_WIDTH);
      h = eff_size(shadow_h, MAX_TEX_HEIGHT);
      while (sent < phase_end) begin
        // Swap the idling of the two sides, then run with none.
        if (sent < total / 3) begin
          send_idle_pct = 30; recv_idle_pct = 71;
        end else if (sent < 2 * total / 3) begin
          send_idle_pct = 71; recv_idle_pct = 30;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        // Hold off the receiver while items keep coming, so the queue backs up.
        if (!held_mid && sent >= total / 2) begin
          held_mid = 1'b1;
          hold_left = 120;
        end
        if (!held_late && sent >= total - 150) begin
          held_late = 1'b1;
          hold_left = 120;
        end
        // Pause the sender until everything owed has come back.
        if (!paused && sent >= total / 4) begin
          paused = 1'b1;
          drain();
        end
        if ($urandom_range(99) < 25) begin
          if ($urandom_range(99) < 70) write_texel(16'($urandom_range(w * h - 1)), 24'($urandom));
          else write_texel(16'($urandom), 24'($urandom));
        end else begin
          if ($urandom_range(99) < 80) begin
            u = 18'($urandom_range(65535));
            v = 18'($urandom_range(65535));
            if ($urandom_range(9) == 0) u = u & ~18'hFF;   // u on a 1/256 step, so no fraction bits of p are cut
          end else begin
            u = 18'($urandom);
            v = 18'($urandom);
          end
          sample_at(u, v, 1'b0, '0);
        end
      end
    end

    drain();
    if (err_cnt == 0 && color_q.size() == 0) begin
      $display("texture_sampler_nearest_bilinear_tb: done, clean");
    end else begin
      $display("texture_sampler_nearest_bilinear_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tsnb_pkg.sv
rtl/tsnb_req_if.sv
rtl/tsnb_rsp_if.sv
rtl/tsnb_cfg_if.sv
rtl/tsnb_front.sv
rtl/tsnb_queue.sv
rtl/tsnb_back.sv
rtl/texture_sampler_nearest_bilinear.sv
rtl/tsnb_checker.sv
tb/sv/texture_sampler_nearest_bilinear_tb.sv
